@@ hw/rtl/p2sm_pkg.sv @@
// ----------------------------------------------------------------------------
// p2sm_pkg
// Shared types, constants and codes for the PS/2 to serial mouse converter.
// ----------------------------------------------------------------------------
package p2sm_pkg;

	localparam int ACC_WIDTH_DEF     = 16;
	localparam int DIVISOR_LIMIT_DEF = 8;
	localparam int DIV_W             = 4;

	typedef enum logic [1:0] {
		OP_PACKET  = 2'd0,
		OP_REPORT  = 2'd1,
		OP_SET_DIV = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	localparam logic [1:0] PM_THREE   = 2'd0;
	localparam logic [1:0] PM_WHEEL   = 2'd1;
	localparam logic [1:0] PM_HDR_TWO = 2'd2;
	localparam logic [1:0] PM_HDR_ONE = 2'd3;

	localparam logic [1:0] WK_NONE  = 2'd0;
	localparam logic [1:0] WK_WHEEL = 2'd1;
	localparam logic [1:0] WK_FIVE  = 2'd2;

	localparam logic CFG_PROTOCOL = 1'b0;
	localparam logic CFG_WHEEL    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_X,
		ST_DIV_Y,
		ST_SCALE,
		ST_REDIV,
		ST_SCALE2,
		ST_EMIT,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic do_packet;
		logic do_setdiv;
		logic do_report;
		logic do_clear;
		logic div_start;
		logic div_sel_y;
		logic scale;
		logic build;
		logic second;
		logic emit_load;
		logic emit_adv;
	} cmd_t;

	typedef struct packed {
		logic idle_report;
		logic serial_on;
		logic div_done;
		logic small_div;
		logic hdr_two;
		logic emit_last;
	} sts_t;

endpackage

@@ hw/rtl/p2sm_ctrl.sv @@
// ----------------------------------------------------------------------------
// p2sm_ctrl
// Sequencer: decodes the item, steps the division and scaling, drives output.
// ----------------------------------------------------------------------------
module p2sm_ctrl
	import p2sm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] opcode,
	input  logic       out_ready,
	input  sts_t       sts,
	output logic       in_ready,
	output logic       out_valid,
	output cmd_t       cmd
);

	state_t state_q, state_nxt;
	logic   second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CHECK) second_q <= 1'b0;
			else if (state_q == ST_SCALE && sts.hdr_two) second_q <= 1'b1;
			else if (state_q == ST_SCALE2) second_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && opcode == OP_REPORT) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.idle_report || !sts.serial_on) state_nxt = ST_IDLE;
				else if (sts.small_div) state_nxt = ST_SCALE;
				else state_nxt = ST_DIV_X;
			end
			ST_DIV_X: if (sts.div_done) state_nxt = ST_DIV_Y;
			ST_DIV_Y: if (sts.div_done) state_nxt = second_q ? ST_SCALE2 : ST_SCALE;
			ST_SCALE: begin
				if (sts.hdr_two && !sts.small_div) state_nxt = ST_REDIV;
				else if (sts.hdr_two) state_nxt = ST_SCALE2;
				else state_nxt = ST_EMIT;
			end
			ST_REDIV:  state_nxt = ST_DIV_X;
			ST_SCALE2: state_nxt = ST_EMIT;
			ST_EMIT:   state_nxt = ST_WAIT;
			ST_WAIT: begin
				if (out_ready && sts.emit_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.do_packet = in_valid && opcode == OP_PACKET;
				cmd.do_setdiv = in_valid && opcode == OP_SET_DIV;
				cmd.do_report = in_valid && opcode == OP_REPORT;
			end
			ST_CHECK: begin
				cmd.do_clear  = !sts.idle_report && !sts.serial_on;
				cmd.div_start = !sts.idle_report && sts.serial_on && !sts.small_div;
			end
			ST_DIV_X: begin
				cmd.div_start = sts.div_done;
				cmd.div_sel_y = sts.div_done;
			end
			ST_DIV_Y: cmd.div_sel_y = 1'b1;
			ST_SCALE: begin
				cmd.scale = 1'b1;
				cmd.build = 1'b1;
			end
			ST_REDIV: cmd.div_start = 1'b1;
			ST_SCALE2: begin
				cmd.scale  = 1'b1;
				cmd.second = 1'b1;
			end
			ST_EMIT: cmd.emit_load = 1'b1;
			ST_WAIT: begin
				out_valid    = 1'b1;
				cmd.emit_adv = out_ready;
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/p2sm_dp.sv @@
// ----------------------------------------------------------------------------
// p2sm_dp
// Datapath: accumulators, buttons, divisor, serial divider and packet bytes.
// ----------------------------------------------------------------------------
module p2sm_dp
	import p2sm_pkg::*;
#(
	parameter int ACC_WIDTH     = ACC_WIDTH_DEF,
	parameter int DIVISOR_LIMIT = DIVISOR_LIMIT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [1:0]       protocol_mode,
	input  logic [1:0]       wheel_kind,
	input  logic [7:0]       flag_byte,
	input  logic [7:0]       x_byte,
	input  logic [7:0]       y_byte,
	input  logic [7:0]       wheel_byte,
	input  logic [DIV_W-1:0] new_divisor,
	input  logic             serial_on,
	output sts_t             sts,
	output logic [7:0]       serial_byte,
	output logic             last_byte
);

	localparam int AW = ACC_WIDTH;
	localparam int CW = $clog2(AW + 1);
	localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic [DIV_W-1:0] DLIM = DIV_W'(DIVISOR_LIMIT);

	logic signed [AW-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic [5:0]           btn_q, sent_q;
	logic [DIV_W-1:0]     div_q;
	logic                 son_q;

	function automatic logic signed [AW-1:0] sat(input logic signed [AW+1:0] v);
		if (v > $signed({{2{AMAX[AW-1]}}, AMAX})) return AMAX;
		if (v < $signed({{2{AMIN[AW-1]}}, AMIN})) return AMIN;
		return v[AW-1:0];
	endfunction

	function automatic logic signed [7:0] cap8(input logic signed [AW-1:0] v);
		if (v > $signed(AW'(127))) return 8'sd127;
		if (v < -$signed(AW'(128))) return -8'sd128;
		return v[7:0];
	endfunction

	// packet decode
	logic signed [AW-1:0] px, py, pz;
	logic [7:0]           zb;
	logic [5:0]           pbtn;
	logic [3:0]           zn;

	always_comb begin
		zb   = (wheel_kind == WK_WHEEL || wheel_kind == WK_FIVE) ? wheel_byte : 8'h00;
		px   = AW'($signed({flag_byte[4], x_byte}));
		py   = AW'($signed({flag_byte[5], y_byte}));
		zn   = zb[3:0];
		pz   = AW'($signed(zn));
		pbtn = {3'b000, flag_byte[2:0]};
		if (zb != 8'h00 && wheel_kind == WK_FIVE) begin
			pbtn[5:4] = zb[5:4];
			if (zb[4]) pbtn[2] = 1'b1;
		end
	end

	// shift-subtract divider on magnitudes
	logic [AW-1:0]        dv_rem_q, dv_quo_q, dv_num;
	logic [CW-1:0]        dv_cnt_q;
	logic                 dv_neg_q, dv_busy_q;
	logic [AW:0]          dv_trial;
	logic signed [AW-1:0] dv_src, q_x_q, q_y_q, quot;

	assign dv_src   = cmd.div_sel_y ? acc_y_q : acc_x_q;
	assign dv_num   = dv_src[AW-1] ? AW'(-dv_src) : dv_src;
	assign dv_trial = {dv_rem_q, dv_quo_q[AW-1]} - {{(AW+1-DIV_W){1'b0}}, div_q};
	assign quot     = dv_neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= CW'(AW);
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 1'b1;
			if (dv_cnt_q == CW'(1)) dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_rem_q <= '0;
			dv_quo_q <= cmd.div_sel_y ? (acc_y_q[AW-1] ? AW'(-acc_y_q) : acc_y_q) : dv_num;
			dv_neg_q <= cmd.div_sel_y ? acc_y_q[AW-1] : dv_src[AW-1];
		end else if (dv_busy_q) begin
			if (!dv_trial[AW]) begin
				dv_rem_q <= dv_trial[AW-1:0];
				dv_quo_q <= {dv_quo_q[AW-2:0], 1'b1};
			end else begin
				dv_rem_q <= {dv_rem_q[AW-2:0], dv_quo_q[AW-1]};
				dv_quo_q <= {dv_quo_q[AW-2:0], 1'b0};
			end
		end
	end

	logic dv_done_q, dv_x_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_done_q <= 1'b0;
			dv_x_q    <= 1'b0;
		end else begin
			dv_done_q <= dv_busy_q && dv_cnt_q == CW'(1);
			if (cmd.div_start) dv_x_q <= !cmd.div_sel_y;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_done_q) begin
			if (dv_x_q) q_x_q <= quot;
			else q_y_q <= quot;
		end
	end

	// scaling
	logic signed [7:0]    sx, sy, sz;
	logic signed [AW+1:0] rx, ry;
	logic signed [AW+DIV_W+1:0] mx, my;
	logic                 div_unit;

	assign div_unit = div_q <= DIV_W'(1);
	assign sz       = cap8(acc_z_q);

	always_comb begin
		if (div_unit) begin
			sx = cap8(acc_x_q);
			sy = cap8(acc_y_q);
			rx = (AW+2)'(acc_x_q) - (AW+2)'(sx);
			ry = (AW+2)'(acc_y_q) - (AW+2)'(sy);
			mx = '0;
			my = '0;
		end else begin
			sx = cap8(q_x_q);
			sy = cap8(q_y_q);
			mx = ((AW+DIV_W+2)'(q_x_q) - (AW+DIV_W+2)'(sx))
				* $signed({2'b00, div_q});
			my = ((AW+DIV_W+2)'(q_y_q) - (AW+DIV_W+2)'(sy))
				* $signed({2'b00, div_q});
			rx = (mx > (AW+DIV_W+2)'(AMAX)) ? (AW+2)'(AMAX) :
				(mx < (AW+DIV_W+2)'(AMIN)) ? (AW+2)'(AMIN) : mx[AW+1:0];
			ry = (my > (AW+DIV_W+2)'(AMAX)) ? (AW+2)'(AMAX) :
				(my < (AW+DIV_W+2)'(AMIN)) ? (AW+2)'(AMIN) : my[AW+1:0];
		end
	end

	// packet bytes
	logic [7:0] b_q [5];
	logic [2:0] n_q, idx_q;
	logic [7:0] hdr_a, hdr_b;
	logic       lmb, rmb, mmb, wbyte;

	assign lmb   = btn_q[0];
	assign rmb   = btn_q[1];
	assign mmb   = btn_q[2];
	assign hdr_a = {2'b01, lmb, rmb, sy[7:6], sx[7:6]};
	assign hdr_b = {5'b10000, !lmb, !mmb, !rmb};
	assign wbyte = protocol_mode == PM_WHEEL && (sz != 8'sd0 || mmb || sent_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			btn_q   <= '0;
			sent_q  <= '0;
			div_q   <= DIV_W'(1);
			son_q   <= 1'b0;
			n_q     <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.do_packet && flag_byte[3]) begin
				acc_x_q <= sat((AW+2)'(acc_x_q) + (AW+2)'(px));
				acc_y_q <= (protocol_mode <= PM_WHEEL) ?
					sat((AW+2)'(acc_y_q) - (AW+2)'(py)) :
					sat((AW+2)'(acc_y_q) + (AW+2)'(py));
				btn_q <= pbtn;
				if (zb != 8'h00) begin
					acc_z_q <= sat((AW+2)'(acc_z_q) + (AW+2)'(pz));
					if (pbtn[2:0] == 3'b111) begin
						if (zn[3]) begin
							if (div_q < DLIM) div_q <= div_q + 1'b1;
						end else if (div_q != '0) div_q <= div_q - 1'b1;
					end
				end
			end
			if (cmd.do_setdiv && new_divisor <= DLIM) div_q <= new_divisor;
			if (cmd.do_report) son_q <= serial_on;
			if (cmd.do_clear) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_z_q <= '0;
				sent_q  <= btn_q;
			end
			if (cmd.scale) begin
				acc_x_q <= rx[AW-1:0];
				acc_y_q <= ry[AW-1:0];
			end
			if (cmd.build) begin
				acc_z_q <= sat((AW+2)'(acc_z_q) - (AW+2)'(sz));
				sent_q  <= btn_q;
				if (protocol_mode <= PM_WHEEL) n_q <= wbyte ? 3'd4 : 3'd3;
				else if (protocol_mode == PM_HDR_TWO) n_q <= 3'd5;
				else n_q <= 3'd3;
			end
			if (cmd.emit_load) idx_q <= '0;
			else if (cmd.emit_adv) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			if (protocol_mode <= PM_WHEEL) begin
				b_q[0] <= hdr_a;
				b_q[1] <= {2'b00, sx[5:0]};
				b_q[2] <= {2'b00, sy[5:0]};
				b_q[3] <= {2'b00, mmb, 1'b0, sz[3:0]};
			end else begin
				b_q[0] <= hdr_b;
				b_q[1] <= sx;
				b_q[2] <= sy;
			end
		end
		if (cmd.second) begin
			b_q[3] <= sx;
			b_q[4] <= sy;
		end
	end

	assign serial_byte = b_q[idx_q];
	assign last_byte   = idx_q == n_q - 3'd1;

	assign sts.idle_report = acc_x_q == '0 && acc_y_q == '0 && acc_z_q == '0 && btn_q == sent_q;
	assign sts.serial_on   = son_q;
	assign sts.div_done    = dv_done_q;
	assign sts.small_div   = div_unit;
	assign sts.hdr_two     = protocol_mode == PM_HDR_TWO;
	assign sts.emit_last   = last_byte;

endmodule

@@ hw/rtl/ps2_mouse_to_serial_mouse.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_to_serial_mouse
// Accumulates PS/2 mouse packets and emits serial mouse reports as bytes.
// ----------------------------------------------------------------------------
// channel  signals                                         direction
// in       in_valid/in_ready, opcode..serial_on           into block
// out      out_valid/out_ready, serial_byte, last_byte     out of block
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data        into block
//
// Packet and set-divisor items are taken in the idle state. A report runs a check
// state, then per division pass the serial divider on X and then on Y
// (two passes with a restart state between them for the header-plus-two-
// motion protocol, none for divisor 0 or 1), a scale state per pass and
// a load state, then emits its bytes in turn while out_ready holds.
// Reset clears accumulators, buttons and control state; divisor resets to one.
// Input is held off until the last beat of a report is taken.
module ps2_mouse_to_serial_mouse
	import p2sm_pkg::*;
#(
	parameter int ACC_WIDTH     = ACC_WIDTH_DEF,
	parameter int DIVISOR_LIMIT = DIVISOR_LIMIT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       opcode,
	input  logic [7:0]       flag_byte,
	input  logic [7:0]       x_byte,
	input  logic [7:0]       y_byte,
	input  logic [7:0]       wheel_byte,
	input  logic [DIV_W-1:0] new_divisor,
	input  logic             serial_on,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       serial_byte,
	output logic             last_byte,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [1:0]       cfg_data
);

	logic [1:0] protocol_mode_q, wheel_kind_q;
	cmd_t       cmd;
	sts_t       sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_mode_q <= PM_THREE;
			wheel_kind_q    <= WK_NONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PROTOCOL: protocol_mode_q <= cfg_data;
				CFG_WHEEL:    wheel_kind_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	p2sm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	p2sm_dp #(
		.ACC_WIDTH     (ACC_WIDTH),
		.DIVISOR_LIMIT (DIVISOR_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.protocol_mode (protocol_mode_q),
		.wheel_kind    (wheel_kind_q),
		.flag_byte     (flag_byte),
		.x_byte        (x_byte),
		.y_byte        (y_byte),
		.wheel_byte    (wheel_byte),
		.new_divisor   (new_divisor),
		.serial_on     (serial_on),
		.sts           (sts),
		.serial_byte   (serial_byte),
		.last_byte     (last_byte)
	);

endmodule

@@ hw/rtl/p2sm_checker.sv @@
// ----------------------------------------------------------------------------
// p2sm_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module p2sm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] serial_byte,
	input logic       last_byte
);

	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during report");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(serial_byte))
		else $error("beat dropped");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !out_valid)
		else $error("beat after last");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> out_valid)
		else $error("report cut short");

endmodule

bind ps2_mouse_to_serial_mouse p2sm_checker u_p2sm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.serial_byte (serial_byte),
	.last_byte   (last_byte)
);
